>>> rtl/core/jgdc_pkg.sv
// Shared types, constants and month table for the Julian/Gregorian date converter.
package jgdc_pkg;

  // Stage counts of the three pipeline sections.
  localparam int DN_STAGES = 3;
  localparam int CY_STAGES = 3;
  localparam int SP_STAGES = 2;
  localparam int N_STAGES  = DN_STAGES + CY_STAGES + SP_STAGES;

  localparam int TDATA_W = 24;

  // Direction and era codes.
  localparam logic FUNC_TO_GREG   = 1'b0;
  localparam logic FUNC_TO_HYBRID = 1'b1;
  localparam logic ERA_BC         = 1'b0;
  localparam logic ERA_AD         = 1'b1;

  // Calendar constants.
  localparam int GREG_CYCLE   = 146097;
  localparam int CENTURY_DAYS = 36525;
  localparam int JULIAN_CYCLE = 1461;
  localparam int MONTHS       = 12;
  localparam int SHARED_YEAR  = 1582;
  localparam int SHARED_MONTH = 10;
  localparam int SHARED_DAY   = 15;

  // Offsets that make the floor divisions work on non-negative values.
  localparam int CEN_OFS  = 256;
  localparam int NY_OFS   = 32768;
  localparam int C_BIAS   = 100 * CEN_OFS;
  localparam int CEN_BIAS = GREG_CYCLE * CEN_OFS;
  localparam int NY_BIAS  = JULIAN_CYCLE * NY_OFS;

  // Reciprocals for division by a constant: q = (v * RCP) >> SH.
  localparam int     RCP100_SH = 22;
  localparam longint RCP100    = ((longint'(1) <<< RCP100_SH) + 100 - 1) / 100;
  localparam int     RCP_GC_SH = 44;
  localparam longint RCP_GC    = ((longint'(1) <<< RCP_GC_SH) + GREG_CYCLE - 1) / GREG_CYCLE;
  localparam int     RCP_JC_SH = 37;
  localparam longint RCP_JC    = ((longint'(1) <<< RCP_JC_SH) + JULIAN_CYCLE - 1) / JULIAN_CYCLE;
  localparam int     RCP_CD_SH = 38;
  localparam longint RCP_CD    = ((longint'(1) <<< RCP_CD_SH) + CENTURY_DAYS - 1) / CENTURY_DAYS;
  localparam int     RCP_MO_SH = 20;
  localparam longint RCP_MO    = ((longint'(1) <<< RCP_MO_SH) + 153 - 1) / 153;

  // Date as it sits in tdata: era in bit 0, then year, month, day.
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        era;
  } date_t;

  typedef struct packed {
    logic  pass;
    logic  func;
    date_t date;
  } ctl_t;

  // Day-number section to cycle-split section.
  typedef struct packed {
    ctl_t        ctl;
    logic [25:0] vg;
    logic [25:0] vj;
    logic [52:0] pjm;
  } dn_t;

  // Cycle-split section to month-split section.
  typedef struct packed {
    ctl_t               ctl;
    logic signed [15:0] yr;
    logic [8:0]         x0;
  } cy_t;

  typedef struct packed {
    date_t date;
    logic  unchanged;
  } res_t;

  // Days from March 1 to the start of month mi (March is 3, months past
  // December continue the count into the next year).
  function automatic logic [8:0] month_offset(input logic [3:0] mi);
    logic [8:0] ofs;
    unique case (mi)
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd13:   ofs = 9'd306;
      4'd14:   ofs = 9'd337;
      4'd15:   ofs = 9'd367;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

>>> rtl/core/jgdc_daynum.sv
// Day-number section: shared-span check, shifted year and biased day counts.
module jgdc_daynum
  import jgdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 func,
  input  date_t                date,
  input  logic [DN_STAGES-1:0] en,
  output logic [DN_STAGES-1:0] vld,
  output dn_t                  dout
);

  typedef struct packed {
    ctl_t               ctl;
    logic [9:0]         dd;
    logic [15:0]        vc;
    logic [31:0]        pc;
    logic signed [26:0] pj;
  } st1_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [9:0]         dd;
    logic signed [9:0]  c;
    logic [6:0]         x;
    logic [25:0]        vj;
  } st2_t;

  st1_t s1, s1_next;
  st2_t s2, s2_next;
  dn_t  s3, s3_next;

  logic [15:0]        sy;
  logic [3:0]         mi;
  logic [9:0]         q;
  logic [15:0]        hq;
  logic signed [27:0] pjf;
  logic signed [27:0] vj_s;
  logic signed [27:0] t;
  logic signed [27:0] tf;
  logic signed [27:0] x1;
  logic signed [27:0] vg_s;

  // Stage 1: shift the year to start in March, look up the month offset.
  always_comb begin
    s1_next.ctl.func = func;
    s1_next.ctl.date = date;
    s1_next.ctl.pass = (date.era == ERA_AD) &&
                       ((date.year > 14'(SHARED_YEAR)) ||
                        ((date.year == 14'(SHARED_YEAR)) &&
                         ((date.month > 4'(SHARED_MONTH)) ||
                          ((date.month == 4'(SHARED_MONTH)) &&
                           (date.day >= 5'(SHARED_DAY))))));
    sy = (date.era == ERA_BC) ? (16'd1 - {2'b00, date.year}) : {2'b00, date.year};
    mi = date.month;
    if (date.month < 4'd3) begin
      sy = sy - 16'd1;
      mi = date.month + 4'(MONTHS);
    end
    s1_next.dd = 10'(month_offset(mi)) + 10'(date.day);
    s1_next.vc = sy + 16'(C_BIAS);
    s1_next.pc = 32'(s1_next.vc) * 32'(RCP100);
    s1_next.pj = $signed({{11{sy[15]}}, sy}) * $signed(27'(JULIAN_CYCLE));
  end

  // Stage 2: century and year-of-century; biased Julian day count.
  always_comb begin
    q  = s1.pc[31:22];
    hq = 16'(q) * 16'd100;
    s2_next.ctl = s1.ctl;
    s2_next.dd  = s1.dd;
    s2_next.c   = $signed(q - 10'(CEN_OFS));
    s2_next.x   = 7'(s1.vc - hq);
    pjf  = $signed({s1.pj[26], s1.pj}) >>> 2;
    vj_s = (pjf <<< 2) + $signed({16'd0, s1.dd, 2'b00}) - 28'sd9 + 28'(CEN_BIAS);
    s2_next.vj = vj_s[25:0];
  end

  // Stage 3: Gregorian day count; start the Julian-to-Gregorian cycle divide.
  always_comb begin
    t    = $signed({{18{s2.c[9]}}, s2.c}) * $signed(28'(GREG_CYCLE));
    tf   = t >>> 2;
    x1   = tf + $signed(28'(s2.x) * 28'd365) + $signed(28'(s2.x[6:2]))
           + $signed(28'(s2.dd)) + 28'sd1;
    vg_s = (x1 <<< 2) + 28'sd3 + 28'(NY_BIAS);
    s3_next.ctl = s2.ctl;
    s3_next.vg  = vg_s[25:0];
    s3_next.vj  = s2.vj;
    s3_next.pjm = 53'(s2.vj) * 53'(RCP_GC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1 <= s1_next;
    if (en[1]) s2 <= s2_next;
    if (en[2]) s3 <= s3_next;
  end

  assign dout = s3;

endmodule

>>> rtl/core/jgdc_cycle.sv
// Cycle-split section: divide day counts into years, keep the day within the year.
module jgdc_cycle
  import jgdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  dn_t                  din,
  input  logic [CY_STAGES-1:0] en,
  output logic [CY_STAGES-1:0] vld,
  output cy_t                  dout
);

  typedef struct packed {
    ctl_t              ctl;
    logic [25:0]       vg;
    logic [52:0]       pg;
    logic [15:0]       x1j;
    logic signed [9:0] cen;
  } st4_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [8:0]         x0g;
    logic signed [15:0] ny;
    logic [44:0]        py;
    logic [15:0]        x1j;
    logic signed [9:0]  cen;
  } st5_t;

  st4_t s4, s4_next;
  st5_t s5, s5_next;
  cy_t  s6, s6_next;

  logic [8:0]         qj;
  logic [25:0]        rj;
  logic [15:0]        qg;
  logic [25:0]        rg;
  logic [21:0]        tj;
  logic [6:0]         ywc;
  logic [15:0]        x0j;
  logic signed [15:0] yj;

  // Stage 4: 400-year cycle quotient and remainder; start the 4-year divide.
  always_comb begin
    qj = din.pjm[52:44];
    rj = din.vj - 26'(qj) * 26'(GREG_CYCLE);
    s4_next.ctl = din.ctl;
    s4_next.vg  = din.vg;
    s4_next.pg  = 53'(din.vg) * 53'(RCP_JC);
    s4_next.x1j = 16'(rj[17:2]);
    s4_next.cen = $signed(10'(qj) - 10'(CEN_OFS));
  end

  // Stage 5: Julian year and day of year; start the century-day divide.
  always_comb begin
    qg = s4.pg[52:37];
    rg = s4.vg - 26'(qg) * 26'(JULIAN_CYCLE);
    tj = 22'(s4.x1j) * 22'd100 + 22'd99;
    s5_next.ctl = s4.ctl;
    s5_next.x0g = rg[10:2];
    s5_next.ny  = $signed(qg - 16'(NY_OFS));
    s5_next.py  = 45'(tj) * 45'(RCP_CD);
    s5_next.x1j = s4.x1j;
    s5_next.cen = s4.cen;
  end

  // Stage 6: Gregorian year and day of year; pick the direction's result.
  always_comb begin
    ywc = s5.py[44:38];
    x0j = s5.x1j - 16'(ywc) * 16'd365 - 16'(ywc[6:2]);
    yj  = $signed({{6{s5.cen[9]}}, s5.cen}) * 16'sd100 + $signed({9'd0, ywc});
    s6_next.ctl = s5.ctl;
    if (s5.ctl.func == FUNC_TO_HYBRID) begin
      s6_next.yr = s5.ny;
      s6_next.x0 = s5.x0g;
    end else begin
      s6_next.yr = yj;
      s6_next.x0 = x0j[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s4 <= s4_next;
    if (en[1]) s5 <= s5_next;
    if (en[2]) s6 <= s6_next;
  end

  assign dout = s6;

endmodule

>>> rtl/core/jgdc_split.sv
// Month-split section: day of year to month and day, era and year, output register.
module jgdc_split
  import jgdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  cy_t                  din,
  input  logic [SP_STAGES-1:0] en,
  output logic [SP_STAGES-1:0] vld,
  output res_t                 dout
);

  typedef struct packed {
    ctl_t               ctl;
    logic signed [15:0] yr;
    logic [8:0]         x0;
    logic [3:0]         mi;
  } st7_t;

  st7_t s7, s7_next;
  res_t s8, s8_next;

  logic [11:0]        tm;
  logic [24:0]        pm;
  logic [9:0]         dsum;
  logic signed [16:0] yadj;
  logic signed [16:0] ybc;

  // Stage 7: month index counted from March.
  always_comb begin
    tm = 12'(din.x0) * 12'd5 + 12'd461;
    pm = 25'(tm) * 25'(RCP_MO);
    s7_next.ctl = din.ctl;
    s7_next.yr  = din.yr;
    s7_next.x0  = din.x0;
    s7_next.mi  = pm[23:20];
  end

  // Stage 8: day of month, wrap January and February into the next year.
  always_comb begin
    dsum = 10'(s7.x0) - 10'(month_offset(s7.mi)) + 10'd1;
    yadj = $signed({s7.yr[15], s7.yr});
    ybc  = 17'sd1 - yadj;
    s8_next.date.day   = dsum[4:0];
    s8_next.date.month = s7.mi;
    if (s7.mi > 4'(MONTHS)) begin
      s8_next.date.month = s7.mi - 4'(MONTHS);
      yadj = yadj + 17'sd1;
      ybc  = 17'sd1 - yadj;
    end
    if (yadj <= 17'sd0) begin
      s8_next.date.era  = ERA_BC;
      s8_next.date.year = ybc[13:0];
    end else begin
      s8_next.date.era  = ERA_AD;
      s8_next.date.year = yadj[13:0];
    end
    s8_next.unchanged = 1'b0;
    if (s7.ctl.pass) begin
      s8_next.date      = s7.ctl.date;
      s8_next.unchanged = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s7 <= s7_next;
    if (en[1]) s8 <= s8_next;
  end

  assign dout = s8;

endmodule

>>> rtl/core/julian_gregorian_date_converter_top.sv
// Top level of the Julian/Gregorian date converter: stream ports and stall control.
//
// Usage:
//   Slave stream s_axis_* carries one date per beat: tdata holds era, year,
//   month and day, tuser holds the direction (0 hybrid to Gregorian,
//   1 Gregorian to hybrid). Master stream m_axis_* returns one converted
//   date per input beat, in order; tuser is set when the date lay on or
//   after 1582-10-15 AD and was passed through as it stood.
//   Path: with the output not stalled, a beat accepted at the input moves through
//   every stage in turn to m_axis_tvalid: three stages build the day count,
//   three divide it into years, two split month and day and hold the result
//   in the output register.
//   Throughput: one date per cycle while no stage holds; every divide is a
//   multiply by a reciprocal, so each stage takes a new beat every cycle.
//   Stall: each stage holds when it is full and the stage after it holds;
//   empty stages keep filling, so s_axis_tready drops only when all eight
//   stages are full and m_axis_tready is low. Nothing is dropped or repeated.
//   Reset: rst, synchronous, clears every stage valid bit; data registers
//   are not reset.
module julian_gregorian_date_converter_top
  import jgdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // era_in, year_in[13:0], month_in[3:0], day_in[4:0]
  input  logic               s_axis_tuser,  // func
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // era_out, year_out[13:0], month_out[3:0], day_out[4:0]
  output logic               m_axis_tuser   // unchanged
);

  logic [N_STAGES-1:0]  vld;
  logic [N_STAGES-1:0]  en;
  logic [DN_STAGES-1:0] dn_vld;
  logic [CY_STAGES-1:0] cy_vld;
  logic [SP_STAGES-1:0] sp_vld;
  dn_t                  dn;
  cy_t                  cy;
  res_t                 res;

  assign vld = {sp_vld, cy_vld, dn_vld};

  // Advance a stage when it is empty or the stage after it advances.
  always_comb begin
    en[N_STAGES-1] = !vld[N_STAGES-1] || m_axis_tready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  jgdc_daynum u_daynum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .func     (s_axis_tuser),
    .date     (date_t'(s_axis_tdata)),
    .en       (en[DN_STAGES-1:0]),
    .vld      (dn_vld),
    .dout     (dn)
  );

  jgdc_cycle u_cycle (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dn_vld[DN_STAGES-1]),
    .din      (dn),
    .en       (en[DN_STAGES+CY_STAGES-1:DN_STAGES]),
    .vld      (cy_vld),
    .dout     (cy)
  );

  jgdc_split u_split (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cy_vld[CY_STAGES-1]),
    .din      (cy),
    .en       (en[N_STAGES-1:DN_STAGES+CY_STAGES]),
    .vld      (sp_vld),
    .dout     (res)
  );

  // The last split stage is the output register.
  assign m_axis_tvalid = sp_vld[SP_STAGES-1];
  assign m_axis_tdata  = res.date;
  assign m_axis_tuser  = res.unchanged;

  // Input backpressure only when the whole pipeline is full and stalled.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline still had room");

  // Passed-through dates always lie in the AD era.
  a_pass_era: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[0] == ERA_AD))
    else $error("pass-through result outside the AD era");

  // A converted date always has a real month.
  a_conv_month: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata[18:15] >= 4'd1 && m_axis_tdata[18:15] <= 4'(MONTHS)))
    else $error("converted month out of range");

  // A converted date never has day zero.
  a_conv_day: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[23:19] != 5'd0))
    else $error("converted day is zero");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the Julian/Gregorian date converter stream block.
module testbench
  import jgdc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIRECTED = 26;
  localparam int NUM_RANDOM   = 1324;
  localparam int TAIL_ITEMS   = 200;   // final stretch with no idling on either side
  localparam int HOLD_AT      = 300;   // random item at which the long output stall starts
  localparam int LONG_HOLD    = 120;   // cycles the receiver holds off in that stall

  // One row of the directed table; the expected date is filled in only where known is set.
  typedef struct {
    logic fn;
    logic era;
    int   year;
    int   month;
    int   day;
    logic known;
    logic exp_era;
    int   exp_year;
    int   exp_month;
    int   exp_day;
    logic exp_unchanged;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;  // era_in, year_in[13:0], month_in[3:0], day_in[4:0]
  logic               s_axis_tuser  = 1'b0; // func
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;         // era_out, year_out[13:0], month_out[3:0], day_out[4:0]
  logic               m_axis_tuser;         // unchanged

  res_t pending_dates[$];
  int   errors         = 0;
  int   passed_through = 0;
  int   converted      = 0;
  int   stall_run      = 0;
  int   longest_stall  = 0;
  bit   tail           = 1'b0;
  bit   hold_req       = 1'b0;

  // Columns: func, era, year, month, day, known, then the typed-in result.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // first day of the shared span, both directions, and dates past it
    '{FUNC_TO_GREG,   ERA_AD, 1582, 10, 15, 1'b1, ERA_AD, 1582, 10, 15, 1'b1},
    '{FUNC_TO_HYBRID, ERA_AD, 1582, 10, 15, 1'b1, ERA_AD, 1582, 10, 15, 1'b1},
    '{FUNC_TO_GREG,   ERA_AD, 1582, 11,  1, 1'b1, ERA_AD, 1582, 11,  1, 1'b1},
    '{FUNC_TO_HYBRID, ERA_AD, 1583,  1,  1, 1'b1, ERA_AD, 1583,  1,  1, 1'b1},
    '{FUNC_TO_GREG,   ERA_AD, 9999, 12, 31, 1'b1, ERA_AD, 9999, 12, 31, 1'b1},
    // all-ones fields in the shared span are copied raw
    '{FUNC_TO_HYBRID, ERA_AD, 16383, 15, 31, 1'b1, ERA_AD, 16383, 15, 31, 1'b1},
    // the day before the shared span and the reform gap
    '{FUNC_TO_GREG,   ERA_AD, 1582, 10, 14, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_HYBRID, ERA_AD, 1582, 10, 14, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_GREG,   ERA_AD, 1582, 10,  4, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_HYBRID, ERA_AD, 1582, 10,  5, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    // around the start of the eras, year zero in anno Domini included
    '{FUNC_TO_GREG,   ERA_BC,    1,  1,  1, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_HYBRID, ERA_BC,    1,  1,  1, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_GREG,   ERA_AD,    0,  3,  1, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_HYBRID, ERA_AD,    0,  2, 29, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_GREG,   ERA_AD,    1,  1,  1, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_HYBRID, ERA_AD,    1,  1,  1, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    // deep before Christ, up to year overflow of the result
    '{FUNC_TO_GREG,   ERA_BC, 9999,  1,  1, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_HYBRID, ERA_BC, 9999, 12, 31, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_GREG,   ERA_BC, 16383, 15, 31, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_HYBRID, ERA_BC, 16383,  0,  0, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    // month and day out of range roll into neighboring dates
    '{FUNC_TO_GREG,   ERA_AD, 1000,  0,  0, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_HYBRID, ERA_AD, 1200, 13, 31, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_GREG,   ERA_AD,  300, 14, 31, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    // leap day that exists in one calendar only, and a February 30
    '{FUNC_TO_HYBRID, ERA_AD,  100,  2, 29, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_GREG,   ERA_AD,  100,  2, 29, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{FUNC_TO_HYBRID, ERA_AD, 1582,  2, 30, 1'b0, 1'b0, 0, 0, 0, 1'b0}
  };

  julian_gregorian_date_converter_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor division, rounding toward minus infinity.
  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // Days from March 1 to the first of month m (m = 3..15, past December runs on).
  function automatic longint days_before_month(input longint m);
    return floor_div(153 * m - 457, 5);
  endfunction

  // Turn a signed year and a day-of-year counted from March 1 into a result date.
  function automatic res_t split_date(input longint sy, input longint doy);
    longint mi;
    longint yv;
    res_t   r;
    mi = floor_div(5 * doy + 461, 153);
    r.date.day = 5'(doy - days_before_month(mi) + 1);
    if (mi > MONTHS) begin
      mi = mi - MONTHS;
      sy++;
    end
    r.date.month = 4'(mi);
    if (sy <= 0) begin
      r.date.era = ERA_BC;
      yv = 1 - sy;
    end else begin
      r.date.era = ERA_AD;
      yv = sy;
    end
    r.date.year  = yv[13:0];   // overflow keeps the low 14 bits
    r.unchanged  = 1'b0;
    return r;
  endfunction

  // Expected result for one date in the given direction.
  function automatic res_t convert_date(input logic fn, input date_t d);
    longint yr, mo, dy, sy, mi;
    longint c, x, x1, x2, ny, cen, ywc;
    res_t   r;
    yr = longint'(d.year);
    mo = longint'(d.month);
    dy = longint'(d.day);
    if (d.era == ERA_AD && (yr > SHARED_YEAR || (yr == SHARED_YEAR &&
        (mo > SHARED_MONTH || (mo == SHARED_MONTH && dy >= SHARED_DAY))))) begin
      r.date      = d;
      r.unchanged = 1'b1;
      return r;
    end
    sy = (d.era == ERA_BC) ? 1 - yr : yr;
    mi = mo;
    // January and February count as months 13 and 14 of the year before
    if (mo < 3) begin
      mi = mo + MONTHS;
      sy--;
    end
    if (fn == FUNC_TO_HYBRID) begin
      c  = floor_div(sy, 100);
      x  = sy - 100 * c;
      x1 = floor_div(GREG_CYCLE * c, 4) + floor_div(CENTURY_DAYS * x, 100)
         + days_before_month(mi) + dy + 1;
      ny = floor_div(4 * x1 + 3, JULIAN_CYCLE);
      r  = split_date(ny, x1 - floor_div(JULIAN_CYCLE * ny, 4));
    end else begin
      x2  = floor_div(JULIAN_CYCLE * sy, 4) + days_before_month(mi) + dy - 3;
      cen = floor_div(4 * x2 + 3, GREG_CYCLE);
      x1  = x2 - floor_div(GREG_CYCLE * cen, 4);
      ywc = floor_div(100 * x1 + 99, CENTURY_DAYS);
      r   = split_date(100 * cen + ywc, x1 - floor_div(CENTURY_DAYS * ywc, 100));
    end
    return r;
  endfunction

  // Drop valid for a random burst before some beats, except in the tail.
  task automatic input_gap();
    if (!tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Offer one date, hold it until accepted, then queue its expected result.
  task automatic send_date(input logic fn, input date_t d, input logic known, input res_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= fn;
    do @(posedge clk); while (!s_axis_tready);
    pending_dates.push_back(known ? want : convert_date(fn, d));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: directed table first, then random dates.
  initial begin
    date_t d;
    res_t  want;
    int    kind;
    int    cap;
    logic  fn;
    while (rst) @(posedge clk);

    foreach (directed_rows[i]) begin
      input_gap();
      d.era            = directed_rows[i].era;
      d.year           = 14'(directed_rows[i].year);
      d.month          = 4'(directed_rows[i].month);
      d.day            = 5'(directed_rows[i].day);
      want.date.era    = directed_rows[i].exp_era;
      want.date.year   = 14'(directed_rows[i].exp_year);
      want.date.month  = 4'(directed_rows[i].exp_month);
      want.date.day    = 5'(directed_rows[i].exp_day);
      want.unchanged   = directed_rows[i].exp_unchanged;
      send_date(directed_rows[i].fn, d, directed_rows[i].known, want);
    end

    want = '0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == NUM_RANDOM - TAIL_ITEMS) tail = 1'b1;
      input_gap();
      fn   = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // dates with in-range months and days (February up to 29), mostly outside the shared span
        d.era = 1'($urandom_range(0, 1));
        if (d.era == ERA_AD)
          d.year = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(1583, 9999))
                                                : 14'($urandom_range(1, SHARED_YEAR));
        else
          d.year = 14'($urandom_range(1, 9999));
        d.month = 4'($urandom_range(1, MONTHS));
        cap = (d.month == 4'd2) ? 29 :
              (d.month == 4'd4 || d.month == 4'd6 || d.month == 4'd9 || d.month == 4'd11) ?
              30 : 31;
        d.day = 5'($urandom_range(1, cap));
      end else if (kind < 70) begin
        // around the calendar reform
        d.era   = ERA_AD;
        d.year  = 14'($urandom_range(1580, 1584));
        d.month = 4'($urandom_range(1, MONTHS));
        d.day   = 5'($urandom_range(1, 31));
      end else if (kind < 80) begin
        // both sides of the era boundary
        d.era   = 1'($urandom_range(0, 1));
        d.year  = 14'($urandom_range(0, 5));
        d.month = 4'($urandom_range(1, MONTHS));
        d.day   = 5'($urandom_range(1, 31));
      end else begin
        // raw field noise over every bit
        d = date_t'(TDATA_W'($urandom()));
      end
      send_date(fn, d, 1'b0, want);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    // Advance past the pipeline depth to catch any stray beat.
    repeat (4 * N_STAGES) @(posedge clk);

    $display("Covered %0d directed and %0d random dates: %0d converted, %0d passed through.",
             NUM_DIRECTED, NUM_RANDOM, converted, passed_through);
    $display("Longest input stall under output back-pressure: %0d cycles.", longest_stall);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random ready bursts, one long hold-off, steady ready in the tail.
  initial begin
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!tail && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Compare each output beat with the oldest queued date; track input stalls.
  always @(posedge clk) begin : out_check
    res_t got;
    res_t want;
    if (!rst) begin
      if (s_axis_tvalid && !s_axis_tready) begin
        stall_run++;
        if (stall_run > longest_stall) longest_stall = stall_run;
      end else begin
        stall_run = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.date      = m_axis_tdata;
        got.unchanged = m_axis_tuser;
        if (pending_dates.size() == 0) begin
          errors++;
          $display("%0t: output beat with no date pending:", $realtime);
          $display("  era %0d year %0d month %0d day %0d unchanged %0d",
                   got.date.era, got.date.year, got.date.month, got.date.day,
                   got.unchanged);
        end else begin
          want = pending_dates.pop_front();
          if (want.unchanged) passed_through++;
          else converted++;
          if (got.date.era != want.date.era || got.date.year != want.date.year ||
              got.date.month != want.date.month || got.date.day != want.date.day ||
              got.unchanged != want.unchanged) begin
            errors++;
            $display("%0t: mismatch, expected era %0d year %0d month %0d day %0d unchanged %0d,",
                     $realtime, want.date.era, want.date.year, want.date.month,
                     want.date.day, want.unchanged);
            $display("  got era %0d year %0d month %0d day %0d unchanged %0d",
                     got.date.era, got.date.year, got.date.month, got.date.day,
                     got.unchanged);
          end
        end
      end
    end
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d dates still pending", $realtime, pending_dates.size());
    $display("simulation failed");
    $finish;
  end

endmodule
